// ----- hdl/bvmw_pkg.sv -----
package bvmw_pkg;

    localparam int VIDEO_ADDR_BITS = 19;
    localparam int VIDEO_DEPTH     = 1 << VIDEO_ADDR_BITS;
    localparam int DIRTY_IDX_BITS  = VIDEO_ADDR_BITS - 4;
    localparam int DIRTY_DEPTH     = 1 << DIRTY_IDX_BITS;
    localparam int EXTRA_IDX_BITS  = 6;
    localparam int EXTRA_DEPTH     = 1 << EXTRA_IDX_BITS;
    localparam int BANK_REG_COUNT  = 4;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_BITS  = 1;

    localparam logic [31:0] BANK_BASE      = 32'h000A_8000;
    localparam logic [31:0] REGWIN_BASE    = 32'h000E_0000;
    localparam logic [31:0] REG_BANK_OFS   = 32'h0000_0004;
    localparam logic [31:0] REG_EXTRA_OFS  = 32'h0000_0100;
    localparam logic [31:0] REG_BANK_MASK  = 32'hFFFF_FFFC;
    localparam logic [31:0] REG_EXTRA_MASK = 32'hFFFF_FFC0;

    // Command groups, taken from command bits 3..2.
    localparam logic [1:0] GRP_FLAT   = 2'd0;
    localparam logic [1:0] GRP_BANK   = 2'd1;
    localparam logic [1:0] GRP_REGWIN = 2'd2;
    localparam logic [1:0] GRP_OTHER  = 2'd3;

    localparam logic [3:0] CMD_DIRTY_RD = 4'd12;

    // Target of one byte step.
    localparam logic [2:0] TGT_NONE    = 3'd0;
    localparam logic [2:0] TGT_FLAT    = 3'd1;
    localparam logic [2:0] TGT_BANK    = 3'd2;
    localparam logic [2:0] TGT_BANKREG = 3'd3;
    localparam logic [2:0] TGT_EXTRA   = 3'd4;
    localparam logic [2:0] TGT_DIRTY   = 3'd5;

    // Source of the data that the collect stage takes for a byte step.
    localparam logic [2:0] SRC_ZERO    = 3'd0;
    localparam logic [2:0] SRC_VIDEO   = 3'd1;
    localparam logic [2:0] SRC_BANKREG = 3'd2;
    localparam logic [2:0] SRC_EXTRA   = 3'd3;
    localparam logic [2:0] SRC_DIRTY   = 3'd4;

    // One byte access. The meaning of addr follows tgt: the video address for
    // the flat aperture, the 16-bit window offset for the banked window (bit 15
    // picks the bank register), the register index for the register window and
    // the entry index for a dirty map read.
    typedef struct packed {
        logic [2:0]                 tgt;
        logic [VIDEO_ADDR_BITS-1:0] addr;
        logic                       plane;
    } byte_op_t;

    typedef struct packed {
        byte_op_t    op0;
        byte_op_t    op1;
        logic        wr;
        logic        word;
        logic [15:0] wdata;
    } item_t;

endpackage

// ----- hdl/banked_video_memory_window_unit.sv -----
// A 512 KiB video memory reached through a flat aperture, a banked window and a
// register window, with a two-plane dirty map and sticky display flags. After
// reset a pass clears all 32768 dirty map entries, one entry per cycle, during
// which full stays high. Items then pass through a two-entry queue to an
// execution unit that performs one byte access per cycle, while the output
// register does not hold back a finished item, on the single-port video memory
// and dirty map; a word access is split into two byte accesses. After the last
// byte access of an item, its data pass through the collect stage into an
// output register, where the result is held so that further items are taken
// while it waits.
module banked_video_memory_window_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [3:0]  command,
    input  logic [31:0] address,
    input  logic [15:0] write_data,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] read_data,
    output logic [1:0]  display_flags
);

    bvmw_pkg::item_t in_item;
    bvmw_pkg::item_t head_item;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    logic            clearing;

    bvmw_front u_front
    (
        .push       (push),
        .full       (full),
        .command    (command),
        .address    (address),
        .write_data (write_data),
        .q_full     (q_full),
        .clearing   (clearing),
        .q_push     (q_push),
        .q_item     (in_item)
    );

    bvmw_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (in_item),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_item (head_item),
        .q_empty (q_empty)
    );

    bvmw_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_item        (head_item),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .clearing      (clearing),
        .empty         (empty),
        .pop           (pop),
        .read_data     (read_data),
        .display_flags (display_flags)
    );

endmodule

// ----- hdl/bvmw_front.sv -----
module bvmw_front
(
    input  logic                 push,
    output logic                 full,
    input  logic [3:0]           command,
    input  logic [31:0]          address,
    input  logic [15:0]          write_data,
    input  logic                 q_full,
    input  logic                 clearing,
    output logic                 q_push,
    output bvmw_pkg::item_t      q_item
);

    function automatic bvmw_pkg::byte_op_t decode_byte(
        input logic [1:0]  grp,
        input logic [31:0] a,
        input logic        plane
    );
        bvmw_pkg::byte_op_t op;
        logic [31:0]        off;
        op       = '0;
        op.plane = plane;
        unique case (grp)
            bvmw_pkg::GRP_FLAT:
            begin
                op.tgt  = bvmw_pkg::TGT_FLAT;
                op.addr = a[bvmw_pkg::VIDEO_ADDR_BITS-1:0];
            end
            bvmw_pkg::GRP_BANK:
            begin
                off     = a - bvmw_pkg::BANK_BASE;
                op.tgt  = bvmw_pkg::TGT_BANK;
                op.addr = {3'b000, off[15:0]};
            end
            bvmw_pkg::GRP_REGWIN:
            begin
                off = a - bvmw_pkg::REGWIN_BASE;
                priority if ((off & bvmw_pkg::REG_BANK_MASK) == bvmw_pkg::REG_BANK_OFS)
                begin
                    op.tgt  = bvmw_pkg::TGT_BANKREG;
                    op.addr = {17'd0, off[1:0]};
                end
                else if ((off & bvmw_pkg::REG_EXTRA_MASK) == bvmw_pkg::REG_EXTRA_OFS)
                begin
                    op.tgt  = bvmw_pkg::TGT_EXTRA;
                    op.addr = {13'd0, off[5:0]};
                end
                else
                begin
                    op.tgt = bvmw_pkg::TGT_NONE;
                end
            end
            default:
            begin
                op.tgt = bvmw_pkg::TGT_NONE;
            end
        endcase
        return op;
    endfunction

    logic [1:0]  grp;
    logic [31:0] address_next_byte;

    assign grp               = command[3:2];
    assign address_next_byte = address + 32'd1;
    assign full              = q_full | clearing;
    assign q_push            = push & ~full;

    always_comb
    begin
        q_item       = '0;
        q_item.wdata = write_data;
        if (grp == bvmw_pkg::GRP_OTHER)
        begin
            if (command == bvmw_pkg::CMD_DIRTY_RD)
            begin
                q_item.op0.tgt  = bvmw_pkg::TGT_DIRTY;
                q_item.op0.addr = {4'd0, address[bvmw_pkg::DIRTY_IDX_BITS-1:0]};
            end
        end
        else
        begin
            // A flat word marks both bytes with the plane of its first byte.
            q_item.wr   = command[0];
            q_item.word = command[1];
            q_item.op0  = decode_byte(grp, address, address[bvmw_pkg::VIDEO_ADDR_BITS-1]);
            q_item.op1  = decode_byte(grp, address_next_byte,
                                      address[bvmw_pkg::VIDEO_ADDR_BITS-1]);
        end
    end

endmodule

// ----- hdl/bvmw_queue.sv -----
module bvmw_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  bvmw_pkg::item_t wr_item,
    output logic            q_full,
    input  logic            rd_en,
    output bvmw_pkg::item_t rd_item,
    output logic            q_empty
);

    bvmw_pkg::item_t                  entries_reg [bvmw_pkg::QUEUE_DEPTH];
    logic [bvmw_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [bvmw_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [bvmw_pkg::QUEUE_PTR_BITS:0]   count_reg;
    logic [bvmw_pkg::QUEUE_PTR_BITS:0]   count_next;

    assign q_full  = (count_reg == (bvmw_pkg::QUEUE_PTR_BITS + 1)'(bvmw_pkg::QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_item = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ----- hdl/bvmw_back.sv -----
module bvmw_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  bvmw_pkg::item_t q_item,
    input  logic            q_empty,
    output logic            q_pop,
    output logic            clearing,
    output logic            empty,
    input  logic            pop,
    output logic [15:0]     read_data,
    output logic [1:0]      display_flags
);

    localparam int VA = bvmw_pkg::VIDEO_ADDR_BITS;
    localparam int DI = bvmw_pkg::DIRTY_IDX_BITS;
    localparam int XI = bvmw_pkg::EXTRA_IDX_BITS;

    // Memories.
    logic [7:0] video_mem [bvmw_pkg::VIDEO_DEPTH];
    logic       dirty_lo_mem [bvmw_pkg::DIRTY_DEPTH];
    logic       dirty_hi_mem [bvmw_pkg::DIRTY_DEPTH];
    logic [7:0] extra_mem [bvmw_pkg::EXTRA_DEPTH];

    logic [7:0]                     bank_regs_reg [bvmw_pkg::BANK_REG_COUNT];
    logic [bvmw_pkg::EXTRA_DEPTH-1:0] extra_valid_reg;
    logic [1:0]                     plane_display_reg;

    logic          clear_active_reg;
    logic [DI-1:0] clear_idx_reg;

    logic byte_idx_reg;

    // Collect stage.
    logic       c_valid_reg;
    logic       c_last_reg;
    logic       c_lane_reg;
    logic [2:0] c_src_reg;
    logic [7:0] acc_reg;

    logic [7:0] video_rdata_reg;
    logic [1:0] dirty_rdata_reg;
    logic [7:0] extra_rdata_reg;
    logic       extra_rvalid_reg;
    logic [7:0] bankreg_rdata_reg;

    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic [1:0]  out_flags_reg;

    bvmw_pkg::byte_op_t cur;
    logic [7:0]         wbyte;
    logic [3:0]         bank_val;
    logic [VA-1:0]      vaddr;
    logic               vplane;
    logic               stall;
    logic               go;
    logic               last;

    logic          v_we;
    logic          v_re;
    logic          d_lo_we;
    logic          d_hi_we;
    logic          d_re;
    logic [DI-1:0] d_addr;
    logic          d_wdata;
    logic          x_we;
    logic          x_re;
    logic          br_we;
    logic          br_re;
    logic          mark;
    logic [2:0]    src;

    logic [7:0]  collect_byte;
    logic [15:0] collect_word;

    assign clearing      = clear_active_reg;
    assign empty         = ~out_valid_reg;
    assign read_data     = out_data_reg;
    assign display_flags = out_flags_reg;

    // The collect stage cannot retire a finished item while the result is held.
    assign stall = c_valid_reg & c_last_reg & out_valid_reg & ~pop;
    assign go    = ~q_empty & ~stall & ~clear_active_reg;
    assign last  = ~q_item.word | byte_idx_reg;
    assign q_pop = go & last;

    assign cur      = byte_idx_reg ? q_item.op1 : q_item.op0;
    assign wbyte    = byte_idx_reg ? q_item.wdata[15:8] : q_item.wdata[7:0];
    assign bank_val = bank_regs_reg[{cur.addr[15], 1'b0}][3:0];

    always_comb
    begin
        if (cur.tgt == bvmw_pkg::TGT_BANK)
        begin
            vaddr  = {bank_val, cur.addr[14:0]};
            vplane = bank_val[3];
        end
        else
        begin
            vaddr  = cur.addr;
            vplane = cur.plane;
        end
    end

    always_comb
    begin
        v_we    = 1'b0;
        v_re    = 1'b0;
        d_re    = 1'b0;
        x_we    = 1'b0;
        x_re    = 1'b0;
        br_we   = 1'b0;
        br_re   = 1'b0;
        mark    = 1'b0;
        src     = bvmw_pkg::SRC_ZERO;
        if (go)
        begin
            unique case (cur.tgt)
                bvmw_pkg::TGT_FLAT, bvmw_pkg::TGT_BANK:
                begin
                    if (q_item.wr)
                    begin
                        v_we = 1'b1;
                        mark = 1'b1;
                    end
                    else
                    begin
                        v_re = 1'b1;
                        src  = bvmw_pkg::SRC_VIDEO;
                    end
                end
                bvmw_pkg::TGT_BANKREG:
                begin
                    if (q_item.wr)
                    begin
                        br_we = 1'b1;
                    end
                    else
                    begin
                        br_re = 1'b1;
                        src   = bvmw_pkg::SRC_BANKREG;
                    end
                end
                bvmw_pkg::TGT_EXTRA:
                begin
                    if (q_item.wr)
                    begin
                        x_we = 1'b1;
                    end
                    else
                    begin
                        x_re = 1'b1;
                        src  = bvmw_pkg::SRC_EXTRA;
                    end
                end
                bvmw_pkg::TGT_DIRTY:
                begin
                    d_re = 1'b1;
                    src  = bvmw_pkg::SRC_DIRTY;
                end
                default:
                begin
                    src = bvmw_pkg::SRC_ZERO;
                end
            endcase
        end
    end

    // The dirty map port serves the clearing pass, marks and entry reads.
    always_comb
    begin
        if (clear_active_reg)
        begin
            d_lo_we = 1'b1;
            d_hi_we = 1'b1;
            d_addr  = clear_idx_reg;
            d_wdata = 1'b0;
        end
        else
        begin
            d_lo_we = mark & ~vplane;
            d_hi_we = mark & vplane;
            d_addr  = d_re ? cur.addr[DI-1:0] : vaddr[DI+2:3];
            d_wdata = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            video_mem[vaddr] <= wbyte;
        end
        if (v_re)
        begin
            video_rdata_reg <= video_mem[vaddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_lo_we)
        begin
            dirty_lo_mem[d_addr] <= d_wdata;
        end
        if (d_hi_we)
        begin
            dirty_hi_mem[d_addr] <= d_wdata;
        end
        if (d_re)
        begin
            dirty_rdata_reg <= {dirty_hi_mem[d_addr], dirty_lo_mem[d_addr]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (x_we)
        begin
            extra_mem[cur.addr[XI-1:0]] <= wbyte;
        end
        if (x_re)
        begin
            extra_rdata_reg <= extra_mem[cur.addr[XI-1:0]];
        end
        if (br_re)
        begin
            bankreg_rdata_reg <= bank_regs_reg[cur.addr[1:0]];
        end
    end

    always_comb
    begin
        unique case (c_src_reg)
            bvmw_pkg::SRC_VIDEO:   collect_byte = video_rdata_reg;
            bvmw_pkg::SRC_BANKREG: collect_byte = bankreg_rdata_reg;
            bvmw_pkg::SRC_EXTRA:   collect_byte = extra_rvalid_reg ? extra_rdata_reg : 8'd0;
            bvmw_pkg::SRC_DIRTY:   collect_byte = {6'd0, dirty_rdata_reg};
            default:               collect_byte = 8'd0;
        endcase
        collect_word = c_lane_reg ? {collect_byte, acc_reg} : {8'd0, collect_byte};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg  <= 1'b1;
            clear_idx_reg     <= '0;
            byte_idx_reg      <= 1'b0;
            c_valid_reg       <= 1'b0;
            c_last_reg        <= 1'b0;
            c_lane_reg        <= 1'b0;
            c_src_reg         <= bvmw_pkg::SRC_ZERO;
            out_valid_reg     <= 1'b0;
            plane_display_reg <= 2'b00;
            extra_valid_reg   <= '0;
            extra_rvalid_reg  <= 1'b0;
            for (int i = 0; i < bvmw_pkg::BANK_REG_COUNT; i++)
            begin
                bank_regs_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (clear_active_reg)
            begin
                clear_idx_reg <= clear_idx_reg + 1'b1;
                if (clear_idx_reg == {DI{1'b1}})
                begin
                    clear_active_reg <= 1'b0;
                end
            end
            if (go)
            begin
                byte_idx_reg <= ~last;
            end
            if (!stall)
            begin
                c_valid_reg <= go;
                c_last_reg  <= last;
                c_lane_reg  <= byte_idx_reg;
                c_src_reg   <= src;
            end
            if (c_valid_reg && c_last_reg && !stall)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            if (mark)
            begin
                plane_display_reg <= plane_display_reg | {vplane, ~vplane};
            end
            if (x_we)
            begin
                extra_valid_reg[cur.addr[XI-1:0]] <= 1'b1;
            end
            if (x_re)
            begin
                extra_rvalid_reg <= extra_valid_reg[cur.addr[XI-1:0]];
            end
            if (br_we)
            begin
                bank_regs_reg[cur.addr[1:0]] <= wbyte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_valid_reg && !stall)
        begin
            if (c_last_reg)
            begin
                out_data_reg  <= collect_word;
                out_flags_reg <= plane_display_reg;
            end
            else
            begin
                acc_reg <= collect_byte;
            end
        end
    end

endmodule
